### rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects i_clk, and CHK_RST also i_rst_n, in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define CHK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define CHK_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/adfs_pkg.sv
package adfs_pkg;

    localparam int VTX_W      = 5;
    localparam int ROW_W      = 32;
    localparam int CNT_W      = 6;
    localparam int VERT_LIMIT = 32;

    localparam logic       KIND_LOAD    = 1'b0;
    localparam logic       KIND_START   = 1'b1;
    localparam logic [5:0] VCOUNT_RESET = 6'd32;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_SCAN = 6'b000100,
        ST_POP  = 6'b001000,
        ST_TOP  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    typedef struct packed {
        logic load_row;
        logic start_init;
        logic emit_err;
        logic push;
        logic pop;
        logic top_load;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic start_ok;
        logic found;
        logic depth_one;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/core/adfs_ram.sv
module adfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/adfs_ctrl.sv
module adfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_kind,
    input  adfs_pkg::t_dp_sts i_sts,
    output adfs_pkg::t_dp_cmd o_cmd,
    output logic              o_in_stall
);

    import adfs_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;
    logic    idle_free;
    logic    accept;

    assign idle_free = (r_state == ST_IDLE) && i_sts.out_free;
    assign accept    = idle_free && i_in_valid;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_LOAD) begin
                        cmd.load_row = 1'b1;
                    end else if (i_sts.start_ok) begin
                        cmd.start_init = 1'b1;
                        n_state        = ST_READ;
                    end else begin
                        cmd.emit_err = 1'b1;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.found) begin
                    if (i_sts.out_free) begin
                        cmd.push = 1'b1;
                        n_state  = ST_READ;
                    end
                end else begin
                    cmd.pop = 1'b1;
                    n_state = i_sts.depth_one ? ST_FIN : ST_POP;
                end
            end
            ST_POP: begin
                n_state = ST_TOP;
            end
            ST_TOP: begin
                cmd.top_load = 1'b1;
                n_state      = ST_SCAN;
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    cmd.finish = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = !idle_free;

endmodule

### rtl/core/adfs_dp.sv
module adfs_dp #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  adfs_pkg::t_dp_cmd           i_cmd,
    output adfs_pkg::t_dp_sts           o_sts,
    input  logic                        i_cfg_valid,
    input  logic [adfs_pkg::CNT_W-1:0]  i_cfg_vertex_count,
    input  logic [adfs_pkg::VTX_W-1:0]  i_row_index,
    input  logic [adfs_pkg::ROW_W-1:0]  i_row_bits,
    input  logic [adfs_pkg::VTX_W-1:0]  i_start_vertex,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [adfs_pkg::VTX_W-1:0]  o_vertex,
    output logic                        o_last,
    output logic                        o_error
);

    import adfs_pkg::*;

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int DW   = $clog2(MAX_VERTICES + 1);
    localparam int NMAX = (MAX_VERTICES < VERT_LIMIT) ? MAX_VERTICES : VERT_LIMIT;

    logic [CNT_W-1:0] r_vcount;
    logic [ROW_W-1:0] r_nmask;
    logic [ROW_W-1:0] r_visited;
    logic [VTX_W-1:0] r_cur;
    logic [VTX_W-1:0] r_pending;
    logic [DW-1:0]    r_depth;
    logic             r_out_valid;
    logic [VTX_W-1:0] r_out_vertex;
    logic             r_out_last;
    logic             r_out_error;

    logic [CNT_W-1:0] n_active;
    logic [ROW_W-1:0] n_mask;
    logic [ROW_W-1:0] adj_rdata;
    logic [ROW_W-1:0] cand;
    logic [VTX_W-1:0] prio;
    logic [VTX_W-1:0] stk_rdata;
    logic [VTX_W-1:0] stk_wdata;
    logic [AW-1:0]    stk_waddr;
    logic [AW-1:0]    stk_raddr;
    logic [DW-1:0]    depth_dec;
    logic [VTX_W-1:0] adj_rvtx;
    logic             adj_we;
    logic             stk_we;
    logic             out_free;
    logic             emit;

    assign n_active = (r_vcount > CNT_W'(NMAX)) ? CNT_W'(NMAX) : r_vcount;

    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            n_mask[j] = (CNT_W'(j) < n_active);
        end
    end

    assign adj_we   = i_cmd.load_row && (int'(i_row_index) < MAX_VERTICES);
    assign adj_rvtx = i_cmd.top_load ? stk_rdata : r_cur;

    adfs_ram #(
        .WIDTH(ROW_W),
        .DEPTH(MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (AW'(i_row_index)),
        .i_wdata (i_row_bits),
        .i_raddr (AW'(adj_rvtx)),
        .o_rdata (adj_rdata)
    );

    assign depth_dec = r_depth - DW'(1);
    assign stk_we    = i_cmd.start_init || i_cmd.push;
    assign stk_waddr = i_cmd.start_init ? '0 : r_depth[AW-1:0];
    assign stk_wdata = i_cmd.start_init ? i_start_vertex : prio;
    assign stk_raddr = depth_dec[AW-1:0];

    adfs_ram #(
        .WIDTH(VTX_W),
        .DEPTH(MAX_VERTICES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign cand = adj_rdata & ~r_visited & r_nmask;

    always_comb begin
        prio = '0;
        for (int j = ROW_W - 1; j >= 0; j--) begin
            if (cand[j]) begin
                prio = VTX_W'(j);
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = i_cmd.push || i_cmd.finish || i_cmd.emit_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= VCOUNT_RESET;
            r_visited   <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_vcount <= i_cfg_vertex_count;
            end
            if (i_cmd.start_init) begin
                r_visited <= ROW_W'(1) << i_start_vertex;
                r_depth   <= DW'(1);
            end else if (i_cmd.push) begin
                r_visited <= r_visited | (ROW_W'(1) << prio);
                r_depth   <= r_depth + DW'(1);
            end else if (i_cmd.pop) begin
                r_depth <= depth_dec;
            end
            r_out_valid <= emit || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_init) begin
            r_nmask   <= n_mask;
            r_cur     <= i_start_vertex;
            r_pending <= i_start_vertex;
        end else if (i_cmd.push) begin
            r_cur     <= prio;
            r_pending <= prio;
        end else if (i_cmd.top_load) begin
            r_cur <= stk_rdata;
        end
        if (i_cmd.emit_err) begin
            r_out_vertex <= '0;
            r_out_last   <= 1'b1;
            r_out_error  <= 1'b1;
        end else if (i_cmd.push || i_cmd.finish) begin
            r_out_vertex <= r_pending;
            r_out_last   <= i_cmd.finish;
            r_out_error  <= 1'b0;
        end
    end

    assign o_sts.start_ok  = (CNT_W'(i_start_vertex) < n_active);
    assign o_sts.found     = |cand;
    assign o_sts.depth_one = (r_depth == DW'(1));
    assign o_sts.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_vertex    = r_out_vertex;
    assign o_last      = r_out_last;
    assign o_error     = r_out_error;

endmodule

### rtl/core/adjacency_matrix_dfs_order.sv
// Channel   Direction  Handshake                  Beat contents
// input     in         i_in_valid / o_in_stall    kind, row_index, row_bits, start_vertex
// output    out        o_out_valid / i_out_stall  vertex, last, error
// config    in         i_cfg_valid / o_cfg_ready  vertex_count
//
// A load item and an out-of-range start are both handled without leaving ST_IDLE.
// A traversal enters a vertex through READ and SCAN and backtracks through SCAN, POP
// and TOP, paced by the registered reads of the row and stack RAMs.
// The last vertex is held until the walk ends, so results lag the walk by one vertex.
// Reset is synchronous; output stalls hold pushes and the finish until the result register frees.
module adjacency_matrix_dfs_order #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_kind,
    input  logic [adfs_pkg::VTX_W-1:0] i_row_index,
    input  logic [adfs_pkg::ROW_W-1:0] i_row_bits,
    input  logic [adfs_pkg::VTX_W-1:0] i_start_vertex,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [adfs_pkg::VTX_W-1:0] o_vertex,
    output logic                       o_last,
    output logic                       o_error,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [adfs_pkg::CNT_W-1:0] i_cfg_vertex_count
);

    import adfs_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    adfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    adfs_dp #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_vertex_count (i_cfg_vertex_count),
        .i_row_index        (i_row_index),
        .i_row_bits         (i_row_bits),
        .i_start_vertex     (i_start_vertex),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_vertex           (o_vertex),
        .o_last             (o_last),
        .o_error            (o_error)
    );

    assign o_cfg_ready = 1'b1;

endmodule

### rtl/core/adfs_checker.sv
`include "assert_macros.svh"

module adfs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       i_kind,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [adfs_pkg::VTX_W-1:0] o_vertex,
    input logic                       o_last,
    input logic                       o_error
);

    import adfs_pkg::*;

    `CHK_RST(a_load_no_result, (i_in_valid && !o_in_stall && i_kind == KIND_LOAD) |=> !o_out_valid, "load item produced a result")

    `CHK_RST(a_error_shape, (o_out_valid && o_error) |-> (o_last && o_vertex == '0), "error beat must be vertex zero with last")

    `CHK_RST(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_vertex) && $stable(o_last) && $stable(o_error)), "stalled result beat changed")

    `CHK_ANY(a_reset_idle, !i_rst_n |=> (!o_out_valid && !o_in_stall), "block not idle after reset")

endmodule

bind adjacency_matrix_dfs_order adfs_checker u_adfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_kind      (i_kind),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_vertex    (o_vertex),
    .o_last      (o_last),
    .o_error     (o_error)
);

### tb/adjacency_matrix_dfs_order_tb.sv
`timescale 1ns / 100ps

module adjacency_matrix_dfs_order_tb;
    import adfs_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 20000;
    localparam int SETTLE       = 12;
    localparam int TAIL         = 200;
    localparam int RAND_ITEMS   = 500;
    localparam int PRESSURE_AT  = 150;
    localparam int DIR_ROWS     = 24;

    typedef enum logic { STEP_ITEM, STEP_CFG } t_step;
    typedef enum logic [1:0] { RX_FREE, RX_COIN, RX_PERIODIC, RX_LIGHT } t_rx_mode;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic             last;
        logic             error;
    } t_visit;

    typedef struct packed {
        logic             kind;
        logic [VTX_W-1:0] row_index;
        logic [ROW_W-1:0] row_bits;
        logic [VTX_W-1:0] start_vertex;
    } t_in_beat;

    typedef struct packed {
        t_step            step;
        logic             kind;
        logic [VTX_W-1:0] row_index;
        logic [ROW_W-1:0] row_bits;
        logic [VTX_W-1:0] start_vertex;
        logic [CNT_W-1:0] cfg_value;
        logic             typed;
        t_visit           want;
    } t_dir_row;

    logic             i_clk              = 1'b0;
    logic             i_rst_n            = 1'b0;
    logic             i_in_valid         = 1'b0;
    logic             i_kind             = KIND_LOAD;
    logic [VTX_W-1:0] i_row_index        = '0;
    logic [ROW_W-1:0] i_row_bits         = '0;
    logic [VTX_W-1:0] i_start_vertex     = '0;
    logic             i_out_stall        = 1'b0;
    logic             i_cfg_valid        = 1'b0;
    logic [CNT_W-1:0] i_cfg_vertex_count = VCOUNT_RESET;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [VTX_W-1:0] o_vertex;
    logic             o_last;
    logic             o_error;
    logic             o_cfg_ready;

    logic [ROW_W-1:0] adj_rows [VERT_LIMIT];
    logic [CNT_W-1:0] vcount_model = VCOUNT_RESET;
    t_visit           pending_visits [$];

    int  burst_left    = 0;
    int  mismatches    = 0;
    int  n_loads       = 0;
    int  n_starts      = 0;
    int  n_out_of_range = 0;
    int  n_visits      = 0;
    int  n_cfg         = 0;
    int  quiet_cycles  = 0;
    bit  pressure_req  = 1'b0;
    bit  pressure_done = 1'b0;

    t_dir_row dir_table [0:DIR_ROWS-1] = '{
        '{STEP_ITEM, KIND_START, 5'd0,  32'h0000_0000, 5'd0,  6'd0,  1'b1, '{5'd0,  1'b1, 1'b0}},
        '{STEP_ITEM, KIND_START, 5'd31, 32'hFFFF_FFFF, 5'd31, 6'd0,  1'b1, '{5'd31, 1'b1, 1'b0}},
        '{STEP_ITEM, KIND_LOAD,  5'd0,  32'hFFFF_FFFF, 5'd31, 6'd0,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_ITEM, KIND_START, 5'd0,  32'h0000_0000, 5'd0,  6'd0,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_ITEM, KIND_LOAD,  5'd31, 32'h8000_0001, 5'd0,  6'd0,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_ITEM, KIND_START, 5'd0,  32'h0000_0000, 5'd31, 6'd0,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_ITEM, KIND_LOAD,  5'd1,  32'h0000_0004, 5'd0,  6'd0,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_ITEM, KIND_LOAD,  5'd2,  32'h0000_0001, 5'd0,  6'd0,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_ITEM, KIND_START, 5'd0,  32'h0000_0000, 5'd1,  6'd0,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_ITEM, KIND_LOAD,  5'd0,  32'h0000_0002, 5'd0,  6'd0,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_ITEM, KIND_START, 5'd0,  32'h0000_0000, 5'd2,  6'd0,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_CFG,  KIND_LOAD,  5'd0,  32'h0000_0000, 5'd0,  6'd0,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_ITEM, KIND_START, 5'd0,  32'h0000_0000, 5'd0,  6'd0,  1'b1, '{5'd0,  1'b1, 1'b1}},
        '{STEP_ITEM, KIND_START, 5'd0,  32'h0000_0000, 5'd31, 6'd0,  1'b1, '{5'd0,  1'b1, 1'b1}},
        '{STEP_CFG,  KIND_LOAD,  5'd0,  32'h0000_0000, 5'd0,  6'd1,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_ITEM, KIND_START, 5'd0,  32'h0000_0000, 5'd0,  6'd0,  1'b1, '{5'd0,  1'b1, 1'b0}},
        '{STEP_ITEM, KIND_START, 5'd0,  32'h0000_0000, 5'd1,  6'd0,  1'b1, '{5'd0,  1'b1, 1'b1}},
        '{STEP_CFG,  KIND_LOAD,  5'd0,  32'h0000_0000, 5'd0,  6'd2,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_ITEM, KIND_START, 5'd0,  32'h0000_0000, 5'd1,  6'd0,  1'b1, '{5'd1,  1'b1, 1'b0}},
        '{STEP_CFG,  KIND_LOAD,  5'd0,  32'h0000_0000, 5'd0,  6'd63, 1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_ITEM, KIND_START, 5'd0,  32'h0000_0000, 5'd31, 6'd0,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_ITEM, KIND_LOAD,  5'd5,  32'hAAAA_AAAA, 5'd0,  6'd0,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_ITEM, KIND_START, 5'd0,  32'h0000_0000, 5'd5,  6'd0,  1'b0, '{5'd0,  1'b0, 1'b0}},
        '{STEP_CFG,  KIND_LOAD,  5'd0,  32'h0000_0000, 5'd0,  6'd32, 1'b0, '{5'd0,  1'b0, 1'b0}}
    };

    adjacency_matrix_dfs_order u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_row_index        (i_row_index),
        .i_row_bits         (i_row_bits),
        .i_start_vertex     (i_start_vertex),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_vertex           (o_vertex),
        .o_last             (o_last),
        .o_error            (o_error),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_vertex_count (i_cfg_vertex_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int eff_count();
        return (vcount_model > VERT_LIMIT) ? VERT_LIMIT : int'(vcount_model);
    endfunction

    task automatic predict_dfs_order(input logic [VTX_W-1:0] start);
        int           n;
        int           depth;
        int           cnt;
        int           top;
        int           v;
        int           r;
        bit           found;
        logic [31:0]  seen;
        int           fr_vertex [VERT_LIMIT];
        int           fr_resume [VERT_LIMIT];
        n = eff_count();
        if (int'(start) >= n) begin
            pending_visits.push_back('{vertex: '0, last: 1'b1, error: 1'b1});
            return;
        end
        seen = '0;
        seen[start] = 1'b1;
        pending_visits.push_back('{vertex: start, last: 1'b0, error: 1'b0});
        cnt = 1;
        fr_vertex[0] = int'(start);
        fr_resume[0] = 0;
        depth = 1;
        while (depth > 0) begin
            top = depth - 1;
            v = fr_vertex[top];
            r = fr_resume[top];
            found = 1'b0;
            while (r < n && !found) begin
                if (adj_rows[v][r] && !seen[r]) found = 1'b1;
                else r++;
            end
            if (found && depth < VERT_LIMIT && cnt < VERT_LIMIT) begin
                fr_resume[top] = r + 1;
                seen[r] = 1'b1;
                pending_visits.push_back('{vertex: VTX_W'(r), last: 1'b0, error: 1'b0});
                cnt++;
                fr_vertex[depth] = r;
                fr_resume[depth] = 0;
                depth++;
            end else begin
                depth--;
            end
        end
        pending_visits[pending_visits.size() - 1].last = 1'b1;
    endtask

    task automatic send_beat(input t_in_beat b, input logic typed, input t_visit want);
        i_in_valid     <= 1'b1;
        i_kind         <= b.kind;
        i_row_index    <= b.row_index;
        i_row_bits     <= b.row_bits;
        i_start_vertex <= b.start_vertex;
        do @(posedge i_clk); while (o_in_stall);
        if (b.kind == KIND_LOAD) begin
            adj_rows[b.row_index] = b.row_bits;
            n_loads++;
        end else begin
            n_starts++;
            if (int'(b.start_vertex) >= eff_count()) n_out_of_range++;
            if (typed) pending_visits.push_back(want);
            else predict_dfs_order(b.start_vertex);
        end
    endtask

    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic write_vertex_count(input logic [CNT_W-1:0] value);
        i_in_valid <= 1'b0;
        while (pending_visits.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_vertex_count <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        vcount_model = value;
        n_cfg++;
    endtask

    initial begin : stimulus
        t_in_beat         beat;
        logic [CNT_W-1:0] cfg;
        int               n;
        int               phase_len;
        int               sent_random;
        sent_random = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every row is written once up front so that no walk reads an unwritten row.
        for (int i = 0; i < VERT_LIMIT; i++) begin
            beat = '{kind: KIND_LOAD, row_index: VTX_W'(i), row_bits: '0, start_vertex: '0};
            send_beat(beat, 1'b0, '0);
            pace_sender();
        end

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_table[i].step == STEP_CFG) begin
                write_vertex_count(dir_table[i].cfg_value);
            end else begin
                beat = '{kind: dir_table[i].kind, row_index: dir_table[i].row_index,
                         row_bits: dir_table[i].row_bits,
                         start_vertex: dir_table[i].start_vertex};
                send_beat(beat, dir_table[i].typed, dir_table[i].want);
                pace_sender();
            end
        end

        while (sent_random < RAND_ITEMS) begin
            case ($urandom_range(0, 5))
                0: cfg = CNT_W'($urandom_range(1, 8));
                1: cfg = CNT_W'($urandom_range(9, 31));
                2: cfg = CNT_W'($urandom_range(33, 63));
                3: cfg = CNT_W'($urandom_range(0, 63));
                default: cfg = VCOUNT_RESET;
            endcase
            write_vertex_count(cfg);
            phase_len = $urandom_range(15, 60);
            for (int j = 0; j < phase_len && sent_random < RAND_ITEMS; j++) begin
                n = eff_count();
                beat.kind = ($urandom_range(0, 99) < 40) ? KIND_START : KIND_LOAD;
                beat.row_index = (n > 0 && $urandom_range(0, 9) < 8)
                               ? VTX_W'($urandom_range(0, n - 1))
                               : VTX_W'($urandom_range(0, 31));
                case ($urandom_range(0, 5))
                    0: beat.row_bits = '0;
                    1: beat.row_bits = '1;
                    2: beat.row_bits = $urandom & $urandom & $urandom;
                    3: beat.row_bits = $urandom;
                    4: beat.row_bits = 32'd1 << $urandom_range(0, 31);
                    default: beat.row_bits = $urandom & $urandom;
                endcase
                beat.start_vertex = (n > 0 && $urandom_range(0, 99) < 85)
                                  ? VTX_W'($urandom_range(0, n - 1))
                                  : VTX_W'($urandom_range(0, 31));
                send_beat(beat, 1'b0, '0);
                sent_random++;
                if (sent_random == PRESSURE_AT) pressure_req = 1'b1;
                pace_sender();
            end
        end

        i_in_valid <= 1'b0;
        while (pending_visits.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        $display("Run covered %0d row loads and %0d traversals (%0d out of range),",
                 n_loads, n_starts, n_out_of_range);
        $display("with %0d visit beats checked over %0d vertex count settings.",
                 n_visits, n_cfg);
        if (mismatches == 0 && pending_visits.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // The receiver mixes free, random and periodic stall patterns, plus one long hold.
    initial begin : out_stall_gen
        t_rx_mode mode;
        int       mode_left;
        int       tick;
        mode = RX_FREE;
        mode_left = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (pressure_req && !pressure_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                pressure_done = 1'b1;
                i_out_stall <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                tick++;
                case (mode)
                    RX_FREE:     i_out_stall <= 1'b0;
                    RX_COIN:     i_out_stall <= ($urandom_range(0, 1) == 1);
                    RX_PERIODIC: i_out_stall <= (tick % 3 == 0);
                    default:     i_out_stall <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : visit_check
        t_visit want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_visits++;
            if (pending_visits.size() == 0) begin
                $error("unexpected visit beat: vertex %0d last %0b error %0b",
                       o_vertex, o_last, o_error);
                mismatches++;
            end else begin
                want = pending_visits.pop_front();
                if (o_vertex !== want.vertex) begin
                    $error("vertex: expected %0d, got %0d", want.vertex, o_vertex);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    mismatches++;
                end
                if (o_error !== want.error) begin
                    $error("error: expected %0b, got %0b", want.error, o_error);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no beat moved for %0d cycles, %0d visits still pending",
                   quiet_cycles, pending_visits.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
